### src/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg: shared types and constants of the scaled convolution core
// Payload structs, configuration indexes and default geometry.
// ----------------------------------------------------------------------------
package scr_pkg;

	localparam int MAX_KERNEL_WIDTH_DEF = 7;
	localparam int MAX_IMAGE_WIDTH_DEF  = 32;

	localparam logic [1:0] REG_KERNEL_WIDTH = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_SCALE        = 2'd2;
	localparam logic [1:0] REG_RELU_ENABLE  = 2'd3;

	localparam logic CMD_WEIGHT = 1'b0;
	localparam logic CMD_PIXEL  = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [5:0]  weight_index;
		logic [7:0]  weight;
		logic [15:0] pixel;
	} in_item_t;

	typedef struct packed {
		logic signed [39:0] conv_value;
		logic [4:0]         out_row;
		logic [4:0]         out_col;
		logic               last;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;   // zero accumulator, latch window origin
		logic mac;     // accumulate one tap
		logic scale;   // multiply sum by scale
		logic finish;  // shift, saturate, rectify into output register
	} dp_cmd_t;

endpackage

### src/scaled_conv2d_relu_core.sv
// ----------------------------------------------------------------------------
// scaled_conv2d_relu_core: scaled valid 2D convolution with optional ReLU
// Weight loads and raster pixels in; one scaled window sum per full window out.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry cmd, weight_index, weight and pixel. cmd 0 writes a
//   kernel weight and is taken without a stall. cmd 1 stores a pixel in the line
//   buffer; when it completes a K-by-K window, the block walks the window
//   with a single multiply-accumulate, one tap per cycle, then scales,
//   shifts, saturates and rectifies. in_stall stays high meanwhile.
//   An item that closes a window holds in_stall until its result is loaded
//   into the output register, so the next item waits until then. Other
//   items are taken without a stall.
//   Results leave through an output register; a result waiting under
//   out_stall is held, and the next window result waits until it is taken.
//   Configuration writes are always ready; writing the kernel size or
//   image_width restarts the frame. Reset clears position, sequencer and
//   registers (K 5, W 28, scale 1.0, ReLU on); weights and the line buffer
//   hold nothing defined until written.
// ----------------------------------------------------------------------------
module scaled_conv2d_relu_core #(
	parameter int MAX_KERNEL_WIDTH = scr_pkg::MAX_KERNEL_WIDTH_DEF,
	parameter int MAX_IMAGE_WIDTH  = scr_pkg::MAX_IMAGE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  scr_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output scr_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);
	import scr_pkg::*;

	localparam int KI_W = $clog2(MAX_KERNEL_WIDTH * MAX_KERNEL_WIDTH);
	localparam int LI_W = $clog2(MAX_KERNEL_WIDTH * MAX_IMAGE_WIDTH);

	logic [2:0]         ksize_q;
	logic [5:0]         image_width_q;
	logic signed [23:0] scale_q;
	logic               relu_enable_q;
	logic               cfg_we, geo_restart;

	logic               wt_we, ln_we, rd_en;
	logic [KI_W-1:0]    wt_waddr, wt_raddr;
	logic [LI_W-1:0]    ln_waddr, ln_raddr;
	dp_cmd_t            cmd;
	logic [4:0]         org_row, org_col;
	logic               org_last;

	assign cfg_ready   = 1'b1;
	assign cfg_we      = cfg_valid && cfg_ready;
	assign geo_restart = cfg_we && (cfg_index == REG_KERNEL_WIDTH
		|| cfg_index == REG_IMAGE_WIDTH);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksize_q        <= 3'd5;
			image_width_q  <= 6'd28;
			scale_q        <= 24'sd65536;
			relu_enable_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KERNEL_WIDTH: ksize_q        <= cfg_data[2:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[5:0];
				REG_SCALE:        scale_q        <= cfg_data;
				REG_RELU_ENABLE:  relu_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	scr_ctrl #(
		.MAX_KERNEL_WIDTH(MAX_KERNEL_WIDTH), .MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH),
		.KI_W(KI_W), .LI_W(LI_W)
	) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_item(in_data),
		.out_valid, .out_stall, .geo_restart,
		.ksize(ksize_q), .image_width(image_width_q),
		.wt_we, .wt_waddr, .ln_we, .ln_waddr, .rd_en, .wt_raddr, .ln_raddr,
		.cmd, .org_row, .org_col, .org_last
	);

	scr_datapath #(
		.MAX_KERNEL_WIDTH(MAX_KERNEL_WIDTH), .MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH),
		.KI_W(KI_W), .LI_W(LI_W)
	) u_dp (
		.clk, .wt_we, .wt_waddr, .wt_wdata(in_data.weight),
		.ln_we, .ln_waddr, .ln_wdata(in_data.pixel),
		.rd_en, .wt_raddr, .ln_raddr, .cmd,
		.scale(scale_q), .relu_enable(relu_enable_q),
		.org_row, .org_col, .org_last, .result(out_data)
	);

endmodule

### src/scr_datapath.sv
// ----------------------------------------------------------------------------
// scr_datapath: weight store, line buffer and shared multiply-accumulate
// One tap per cycle; scaling and output formatting follow in two steps.
// ----------------------------------------------------------------------------
module scr_datapath #(
	parameter int MAX_KERNEL_WIDTH = 7,
	parameter int MAX_IMAGE_WIDTH  = 32,
	parameter int KI_W = $clog2(MAX_KERNEL_WIDTH * MAX_KERNEL_WIDTH),
	parameter int LI_W = $clog2(MAX_KERNEL_WIDTH * MAX_IMAGE_WIDTH)
) (
	input  logic                  clk,
	input  logic                  wt_we,
	input  logic [KI_W-1:0]       wt_waddr,
	input  logic [7:0]            wt_wdata,
	input  logic                  ln_we,
	input  logic [LI_W-1:0]       ln_waddr,
	input  logic [15:0]           ln_wdata,
	input  logic                  rd_en,
	input  logic [KI_W-1:0]       wt_raddr,
	input  logic [LI_W-1:0]       ln_raddr,
	input  scr_pkg::dp_cmd_t      cmd,
	input  logic signed [23:0]    scale,
	input  logic                  relu_enable,
	input  logic [4:0]            org_row,
	input  logic [4:0]            org_col,
	input  logic                  org_last,
	output scr_pkg::out_item_t    result
);
	import scr_pkg::*;

	localparam int KSTORE = MAX_KERNEL_WIDTH * MAX_KERNEL_WIDTH;
	localparam int LSTORE = MAX_KERNEL_WIDTH * MAX_IMAGE_WIDTH;

	logic [7:0]  wt_mem [KSTORE];
	logic [15:0] ln_mem [LSTORE];
	logic [7:0]  wt_rd_q;
	logic [15:0] px_rd_q;
	logic [31:0] sum_q;
	logic signed [64:0] prod_q;
	logic [4:0]  row_q, col_q;
	logic        last_q;
	logic signed [48:0] shifted;
	logic signed [39:0] sat;

	always_ff @(posedge clk) begin
		if (wt_we) wt_mem[wt_waddr] <= wt_wdata;
		if (ln_we) ln_mem[ln_waddr] <= ln_wdata;
		if (rd_en) begin
			wt_rd_q <= wt_mem[wt_raddr];
			px_rd_q <= ln_mem[ln_raddr];
		end
	end

	// floor shift of the signed product; 65 bits keep sum*scale exact
	assign shifted = 49'(prod_q >>> 16);

	always_comb begin
		if (shifted > 49'sd549755813887) sat = 40'sh7FFFFFFFFF;
		else if (shifted < -49'sd549755813888) sat = 40'sh8000000000;
		else sat = shifted[39:0];
		if (relu_enable && sat[39]) sat = '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			sum_q  <= '0;
			row_q  <= org_row;
			col_q  <= org_col;
			last_q <= org_last;
		end else if (cmd.mac) begin
			sum_q <= sum_q + 32'(wt_rd_q * px_rd_q);
		end
		if (cmd.scale) prod_q <= $signed({1'b0, sum_q}) * scale;
		if (cmd.finish) begin
			result.conv_value <= sat;
			result.out_row    <= row_q;
			result.out_col    <= col_q;
			result.last       <= last_q;
		end
	end

endmodule

### src/scr_ctrl.sv
// ----------------------------------------------------------------------------
// scr_ctrl: sequencer of the convolution core
// Tracks raster position, walks the window and runs the output handshake.
// ----------------------------------------------------------------------------
module scr_ctrl #(
	parameter int MAX_KERNEL_WIDTH = 7,
	parameter int MAX_IMAGE_WIDTH  = 32,
	parameter int KI_W = $clog2(MAX_KERNEL_WIDTH * MAX_KERNEL_WIDTH),
	parameter int LI_W = $clog2(MAX_KERNEL_WIDTH * MAX_IMAGE_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  scr_pkg::in_item_t     in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  geo_restart,
	input  logic [2:0]            ksize,
	input  logic [5:0]            image_width,
	output logic                  wt_we,
	output logic [KI_W-1:0]       wt_waddr,
	output logic                  ln_we,
	output logic [LI_W-1:0]       ln_waddr,
	output logic                  rd_en,
	output logic [KI_W-1:0]       wt_raddr,
	output logic [LI_W-1:0]       ln_raddr,
	output scr_pkg::dp_cmd_t      cmd,
	output logic [4:0]            org_row,
	output logic [4:0]            org_col,
	output logic                  org_last
);
	import scr_pkg::*;

	localparam int KSTORE = MAX_KERNEL_WIDTH * MAX_KERNEL_WIDTH;
	localparam int KW_W = $clog2(MAX_KERNEL_WIDTH + 1);
	localparam int IW_W = $clog2(MAX_IMAGE_WIDTH + 1);
	localparam int PW   = $clog2(MAX_IMAGE_WIDTH);
	localparam int LW   = $clog2(MAX_KERNEL_WIDTH);
	localparam int LIW  = (LW < 1) ? 1 : LW;

	typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_SCALE, S_FIN} state_t;

	state_t           state_q;
	logic [PW-1:0]    row_q, col_q;
	logic [LIW-1:0]   line_q;     // row_q mod max kernel width
	logic [LIW-1:0]   rd_line_q;
	logic [KW_W-1:0]  kr_q, kc_q;
	logic [KI_W-1:0]  widx_q;
	logic [PW-1:0]    c0_q;
	logic             out_valid_q;

	logic [KW_W-1:0]  k_eff;
	logic [IW_W-1:0]  w_eff;
	logic             accept, is_px, win_ok, tap_last, fin_go;
	logic [31:0]      start_sum;
	logic [LIW-1:0]   start_line;

	always_comb begin
		if (ksize == 3'd0) k_eff = KW_W'(1);
		else if (32'(ksize) > MAX_KERNEL_WIDTH) k_eff = KW_W'(MAX_KERNEL_WIDTH);
		else k_eff = KW_W'(ksize);
		if (image_width == 6'd0) w_eff = IW_W'(1);
		else if (32'(image_width) > MAX_IMAGE_WIDTH) w_eff = IW_W'(MAX_IMAGE_WIDTH);
		else w_eff = IW_W'(image_width);
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && !in_stall;
	assign is_px     = in_item.cmd == CMD_PIXEL;
	assign win_ok    = (32'(k_eff) <= 32'(w_eff)) && (32'(row_q) + 1 >= 32'(k_eff))
		&& (32'(col_q) + 1 >= 32'(k_eff));
	assign tap_last  = (kr_q == k_eff - 1'b1) && (kc_q == k_eff - 1'b1);
	assign fin_go    = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// oldest window row: (line - k + 1) mod max kernel width, by one compare
	assign start_sum  = 32'(line_q) + 32'(MAX_KERNEL_WIDTH) + 32'd1 - 32'(k_eff);
	assign start_line = (start_sum >= 32'(MAX_KERNEL_WIDTH))
		? LIW'(start_sum - 32'(MAX_KERNEL_WIDTH)) : LIW'(start_sum);

	assign wt_we    = accept && !is_px && (32'(in_item.weight_index) < KSTORE);
	assign wt_waddr = KI_W'(in_item.weight_index);
	assign ln_we    = accept && is_px;
	assign ln_waddr = LI_W'(32'(line_q) * MAX_IMAGE_WIDTH + 32'(col_q));
	assign rd_en    = (state_q == S_MAC);
	assign wt_raddr = widx_q;
	assign ln_raddr = LI_W'(32'(rd_line_q) * MAX_IMAGE_WIDTH + 32'(c0_q) + 32'(kc_q));

	assign org_row  = 5'(32'(row_q) + 1 - 32'(k_eff));
	assign org_col  = 5'(32'(col_q) + 1 - 32'(k_eff));
	assign org_last = (32'(row_q) + 1 == 32'(w_eff)) && (32'(col_q) + 1 == 32'(w_eff));

	always_comb begin
		cmd = '0;
		cmd.clear  = accept && is_px && win_ok;
		cmd.mac    = ((state_q == S_MAC) && (widx_q != '0)) || (state_q == S_DRAIN);
		cmd.scale  = (state_q == S_SCALE);
		cmd.finish = fin_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q <= '0; col_q <= '0; line_q <= '0;
			rd_line_q <= '0;
			kr_q <= '0; kc_q <= '0; widx_q <= '0; c0_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (geo_restart) begin
				row_q <= '0; col_q <= '0; line_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && is_px) begin
						// advance raster position
						if (!geo_restart) begin
							if (32'(col_q) + 1 >= 32'(w_eff)) begin
								col_q <= '0;
								if (32'(row_q) + 1 >= 32'(w_eff)) begin
									row_q <= '0; line_q <= '0;
								end else begin
									row_q <= row_q + 1'b1;
									line_q <= (32'(line_q) == MAX_KERNEL_WIDTH - 1) ? '0
										: line_q + 1'b1;
								end
							end else begin
								col_q <= col_q + 1'b1;
							end
						end
						if (win_ok) begin
							rd_line_q <= start_line;
							c0_q <= PW'(32'(col_q) + 1 - 32'(k_eff));
							kr_q <= '0; kc_q <= '0; widx_q <= '0;
							state_q <= S_MAC;
						end
					end
				end
				S_MAC: begin
					// issue one tap read a cycle; the registered data is summed in the cycle after
					if (tap_last) begin
						state_q <= S_DRAIN;
					end else begin
						widx_q <= widx_q + 1'b1;
						if (kc_q == k_eff - 1'b1) begin
							kc_q <= '0;
							kr_q <= kr_q + 1'b1;
							rd_line_q <= (32'(rd_line_q) == MAX_KERNEL_WIDTH - 1) ? '0
								: rd_line_q + 1'b1;
						end else begin
							kc_q <= kc_q + 1'b1;
						end
					end
				end
				S_DRAIN: state_q <= S_SCALE;
				S_SCALE: state_q <= S_FIN;
				S_FIN: begin
					// hold while the previous beat waits under out_stall, then load and present
					if (fin_go) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ast_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("accept while busy");
	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q) else $error("beat dropped");
	ast_fin_presents: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid_q) else $error("finish sequence broken");

endmodule
